### rtl/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg: shared types and constants of the double-ended queue
// Holds the queue geometry, the command and status codes and the structs
// that pass between the control logic, the slot memory and the top level.
// ----------------------------------------------------------------------------
package deq_pkg;

	// Queue geometry. DEPTH need not be a power of two: all index arithmetic
	// wraps explicitly.
	localparam int DEPTH      = 16;
	localparam int DATA_WIDTH = 32;
	localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W      = $clog2(DEPTH + 1);

	// Fixed widths of the transaction fields.
	localparam int CMD_W    = 3;
	localparam int VALUE_W  = 32;
	localparam int COUNT_W  = 5;
	localparam int STATUS_W = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH_FRONT = 3'd0,
		CMD_PUSH_BACK  = 3'd1,
		CMD_POP_FRONT  = 3'd2,
		CMD_POP_BACK   = 3'd3,
		CMD_PEEK_FRONT = 3'd4,
		CMD_PEEK_BACK  = 3'd5
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// One access to the slot memory.
	typedef struct packed {
		logic                  we;
		logic                  re;
		logic [ADDR_W-1:0]     addr;
		logic [DATA_WIDTH-1:0] wdata;
	} mem_req_t;

	// What the result needs besides the word read from memory.
	typedef struct packed {
		logic                 rd_used;
		logic [COUNT_W-1:0]   count;
		status_t              status;
	} res_meta_t;

endpackage

### rtl/deq_if.sv
// ----------------------------------------------------------------------------
// deq_cmd_if / deq_res_if: valid-ready channels of the double-ended queue
// The command channel carries cmd and value; the result channel carries
// data, count and status.
// ----------------------------------------------------------------------------
interface deq_cmd_if;
	logic        valid;
	logic        ready;
	logic [2:0]  cmd;
	logic [31:0] value;

	modport source (output valid, output cmd, output value, input ready);
	modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface deq_res_if;
	logic        valid;
	logic        ready;
	logic [31:0] data;
	logic [4:0]  count;
	logic [1:0]  status;

	modport source (output valid, output data, output count, output status, input ready);
	modport sink   (input valid, input data, input count, input status, output ready);
endinterface

### rtl/deq_ram.sv
// ----------------------------------------------------------------------------
// deq_ram: slot storage of the double-ended queue
// One synchronous port; a read loads its word into the read register at the
// clock edge, and the read register holds until the next read.
// ----------------------------------------------------------------------------
module deq_ram
	import deq_pkg::*;
(
	input  logic                  clk,
	input  mem_req_t              req,
	output logic [DATA_WIDTH-1:0] rdata
);

	logic [DATA_WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr] <= req.wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (req.re) begin
			rdata <= mem[req.addr];
		end
	end

endmodule

### rtl/deq_ctrl.sv
// ----------------------------------------------------------------------------
// deq_ctrl: pointer and count keeping of the double-ended queue
// Decodes a command, chooses the slot it touches, issues the memory access
// and updates the front index and element count when the command is taken.
// ----------------------------------------------------------------------------
module deq_ctrl
	import deq_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic [CMD_W-1:0]   cmd,
	input  logic [VALUE_W-1:0] value,
	output mem_req_t           mem_req,
	output res_meta_t          meta
);

	localparam int SUM_W = ADDR_W + 1;
	localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(DEPTH);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

	logic [ADDR_W-1:0] front_q;
	logic [CNT_W-1:0]  count_q;

	logic [ADDR_W-1:0] front_d;
	logic [CNT_W-1:0]  count_d;
	logic [ADDR_W-1:0] front_dec, front_inc, back_pos, tail_pos;
	logic [SUM_W-1:0]  sum_tail, sum_back, sum_inc;
	logic              full, empty;
	status_t           status;
	logic              we, re;
	logic [ADDR_W-1:0] addr;

	// Sums stay below twice DEPTH, so one conditional subtract wraps them.
	assign sum_tail  = SUM_W'(front_q) + SUM_W'(count_q);
	assign sum_back  = sum_tail - SUM_W'(1);
	assign sum_inc   = SUM_W'(front_q) + SUM_W'(1);
	assign tail_pos  = ADDR_W'((sum_tail >= DEPTH_S) ? sum_tail - DEPTH_S : sum_tail);
	assign back_pos  = ADDR_W'((sum_back >= DEPTH_S) ? sum_back - DEPTH_S : sum_back);
	assign front_inc = ADDR_W'((sum_inc >= DEPTH_S) ? sum_inc - DEPTH_S : sum_inc);
	assign front_dec = (front_q == '0) ? ADDR_W'(DEPTH - 1) : front_q - ADDR_W'(1);

	assign full  = (count_q == DEPTH_C);
	assign empty = (count_q == '0);

	always_comb begin
		front_d = front_q;
		count_d = count_q;
		status  = ST_OK;
		we      = 1'b0;
		re      = 1'b0;
		addr    = front_q;
		case (cmd_t'(cmd))
			CMD_PUSH_FRONT: begin
				if (full) begin
					status = ST_FULL;
				end else begin
					we      = 1'b1;
					addr    = front_dec;
					front_d = front_dec;
					count_d = count_q + CNT_W'(1);
				end
			end
			CMD_PUSH_BACK: begin
				if (full) begin
					status = ST_FULL;
				end else begin
					we      = 1'b1;
					addr    = tail_pos;
					count_d = count_q + CNT_W'(1);
				end
			end
			CMD_POP_FRONT, CMD_PEEK_FRONT: begin
				if (empty) begin
					status = ST_EMPTY;
				end else begin
					re   = 1'b1;
					addr = front_q;
					if (cmd_t'(cmd) == CMD_POP_FRONT) begin
						front_d = front_inc;
						count_d = count_q - CNT_W'(1);
					end
				end
			end
			CMD_POP_BACK, CMD_PEEK_BACK: begin
				if (empty) begin
					status = ST_EMPTY;
				end else begin
					re   = 1'b1;
					addr = back_pos;
					if (cmd_t'(cmd) == CMD_POP_BACK) begin
						count_d = count_q - CNT_W'(1);
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign mem_req.we    = accept && we;
	assign mem_req.re    = accept && re;
	assign mem_req.addr  = addr;
	assign mem_req.wdata = DATA_WIDTH'(value);

	assign meta.rd_used = re;
	assign meta.count   = COUNT_W'(count_d);
	assign meta.status  = status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
		end else if (accept) begin
			front_q <= front_d;
			count_q <= count_d;
		end
	end

endmodule

### rtl/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue: bounded double-ended queue in a ring buffer
// Push and pop at either end, peek at either end, with empty and full
// errors reported per command. One result transaction per command.
//
//   Channel  Dir  Payload                     Transaction when
//   req      in   cmd[2:0], value[31:0]       req.valid && req.ready
//   rsp      out  data[31:0], count[4:0],     rsp.valid && rsp.ready
//                 status[1:0]
//
// An accepted command's read word lands in the memory read register while the
// command sits in stage 1; the result then moves into the output register, from
// which its result transaction completes; the registered memory read sets that stage.
// Commands are taken back to back, one per cycle, while the result side
// keeps draining; the single-port slot memory does one access per cycle.
// Reset clears the front index, the element count and both valid flags;
// the slot memory is not cleared, as only written slots are ever read.
// A stalled result holds the pipeline; req.ready falls only when both the
// middle stage and the output register are full and rsp.ready is low.
// ----------------------------------------------------------------------------
module double_ended_queue
	import deq_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	deq_cmd_if.sink    req,
	deq_res_if.source  rsp
);

	logic                  accept;
	logic                  adv_s1;
	mem_req_t              mem_req;
	res_meta_t             meta;
	logic [DATA_WIDTH-1:0] rdata;

	// Stage 1: the command has issued its memory access; the read word
	// shows up in the memory's read register during this stage.
	logic                  valid_s1;
	res_meta_t             meta_s1;

	// Output register.
	logic                  rsp_valid_q;
	logic [VALUE_W-1:0]    data_q;
	logic [COUNT_W-1:0]    count_q;
	status_t               status_q;

	// Stage 1 moves on whenever the output register is empty or being
	// drained. The memory read register is written only by an accepted
	// command, so it holds its word while stage 1 waits.
	assign adv_s1    = !rsp_valid_q || rsp.ready;
	assign req.ready = !valid_s1 || adv_s1;
	assign accept    = req.valid && req.ready;

	deq_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.cmd     (req.cmd),
		.value   (req.value),
		.mem_req (mem_req),
		.meta    (meta)
	);

	deq_ram u_ram (
		.clk   (clk),
		.req   (mem_req),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				rsp_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			meta_s1 <= meta;
		end
		if (adv_s1 && valid_s1) begin
			// Pushes, errors and unused commands return a zero data word.
			data_q   <= meta_s1.rd_used ? VALUE_W'(rdata) : '0;
			count_q  <= meta_s1.count;
			status_q <= meta_s1.status;
		end
	end

	assign rsp.valid  = rsp_valid_q;
	assign rsp.data   = data_q;
	assign rsp.count  = count_q;
	assign rsp.status = status_q;

endmodule
